// ===== rtl/prrt_pkg.sv =====
`timescale 1ns / 1ps
package prrt_pkg;
  localparam logic [1:0] MODE_SEND = 2'd0;
  localparam logic [1:0] MODE_ACK  = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;
  localparam logic ACT_RETX = 1'b0;
  localparam logic ACT_FAIL = 1'b1;
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_MAXRETRY = 1'b1;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;
  localparam logic [3:0] MAXRETRY_RST = 4'd3;
endpackage

// ===== rtl/pending_request_retransmit_tracker_core.sv =====
`timescale 1ns / 1ps
// channel | ports                                      | dir
// in      | in_valid/in_ready, in_mode, in_ack_id, ... | sink
// out     | out_valid/out_ready, out_action, ...        | source
// cfg     | cfg_we, cfg_index, cfg_data                 | sink
// A send or ack scans all DEPTH slots one per cycle through one id comparator,
// then decides and relinks the age list.
// A tick reads the oldest slot only, and emits a result when it has timed out.
// The id match scan sets the rate.
// Reset (rst_n low, synchronous) clears valid bits, oldest/newest pointers, count; loads config defaults.
// A result waits in the output register; the next input beat is taken only
// after that result is delivered.
module pending_request_retransmit_tracker_core #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_ack_id,
  input  logic [15:0] in_buffer_handle,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_action,
  output logic [31:0] out_ack_id,
  output logic [15:0] out_handle,
  output logic [3:0]  out_attempt
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_EVICT, S_INSERT, S_MOVE, S_DROP,
    S_TRD, S_TCHK, S_OUT
  } state_t;

  logic [15:0] timeout_r;
  logic [3:0]  maxr_r;
  state_t      state_r;
  logic [DEPTH-1:0] valid_r;
  logic [31:0] id_mem [DEPTH];
  logic [15:0] hd_mem [DEPTH];
  logic [31:0] tm_mem [DEPTH];
  logic [3:0]  rt_mem [DEPTH];
  logic [AW-1:0] older_r [DEPTH];
  logic [AW-1:0] newer_r [DEPTH];
  logic [AW-1:0] oldest_r, newest_r;
  logic [CW-1:0] count_r;

  logic [1:0]  mode_r;
  logic [31:0] id_r, now_r;
  logic [15:0] hnd_r;
  logic [CW-1:0] scan_r;
  logic          hit_r, fre_r;
  logic [AW-1:0] hit_slot_r, fre_slot_r, tgt_r;
  logic [31:0] rd_id_r, rd_tm_r;
  logic [15:0] rd_hd_r;
  logic [3:0]  rd_rt_r;

  logic [AW-1:0] sidx;
  assign sidx = scan_r[AW-1:0];
  assign in_ready = (state_r == S_IDLE) && !out_valid;

  // detach helper values for tgt_r
  logic [AW-1:0] t_o, t_n;
  assign t_o = older_r[tgt_r];
  assign t_n = newer_r[tgt_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= prrt_pkg::TIMEOUT_RST;
      maxr_r    <= prrt_pkg::MAXRETRY_RST;
      state_r   <= S_IDLE;
      valid_r   <= '0;
      oldest_r  <= '0;
      newest_r  <= '0;
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          prrt_pkg::CFG_TIMEOUT:  timeout_r <= cfg_data;
          prrt_pkg::CFG_MAXRETRY: maxr_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          mode_r <= in_mode; id_r <= in_ack_id; hnd_r <= in_buffer_handle;
          now_r <= in_now_ms; scan_r <= '0; hit_r <= 1'b0; fre_r <= 1'b0;
          case (in_mode)
            prrt_pkg::MODE_SEND, prrt_pkg::MODE_ACK: state_r <= S_SCAN;
            prrt_pkg::MODE_TICK: state_r <= (count_r == '0) ? S_IDLE : S_TRD;
            default: state_r <= S_IDLE;
          endcase
        end
        S_SCAN: begin
          // one slot per cycle through the shared comparator
          if (valid_r[sidx] && id_mem[sidx] == id_r && !hit_r) begin
            hit_r <= 1'b1; hit_slot_r <= sidx;
          end
          if (!valid_r[sidx] && !fre_r) begin
            fre_r <= 1'b1; fre_slot_r <= sidx;
          end
          if (scan_r == CW'(DEPTH - 1)) state_r <= S_DECIDE;
          scan_r <= scan_r + 1'b1;
        end
        S_DECIDE: begin
          if (mode_r == prrt_pkg::MODE_ACK) begin
            tgt_r <= hit_slot_r;
            state_r <= hit_r ? S_DROP : S_IDLE;
          end else if (hit_r) begin
            tm_mem[hit_slot_r] <= now_r;
            tgt_r <= hit_slot_r;
            state_r <= (hit_slot_r == newest_r) ? S_IDLE : S_MOVE;
          end else if (count_r >= CW'(DEPTH)) begin
            tgt_r <= oldest_r; fre_slot_r <= oldest_r;
            state_r <= S_EVICT;
          end else begin
            state_r <= S_INSERT;
          end
        end
        S_EVICT: begin
          // table full: oldest goes, its slot takes the new entry
          if (count_r > 1) oldest_r <= t_n;
          valid_r[tgt_r] <= 1'b0;
          count_r <= count_r - 1'b1;
          state_r <= S_INSERT;
        end
        S_INSERT: begin
          valid_r[fre_slot_r] <= 1'b1;
          id_mem[fre_slot_r] <= id_r; hd_mem[fre_slot_r] <= hnd_r;
          tm_mem[fre_slot_r] <= now_r; rt_mem[fre_slot_r] <= '0;
          if (count_r == '0) begin
            oldest_r <= fre_slot_r; newest_r <= fre_slot_r;
          end else begin
            newer_r[newest_r] <= fre_slot_r;
            older_r[fre_slot_r] <= newest_r;
            newest_r <= fre_slot_r;
          end
          count_r <= count_r + 1'b1;
          state_r <= S_IDLE;
        end
        S_MOVE: begin
          // tgt is not newest and count>1: detach then append
          if (tgt_r == oldest_r) oldest_r <= t_n;
          else begin
            newer_r[t_o] <= t_n;
            older_r[t_n] <= t_o;
          end
          newer_r[newest_r] <= tgt_r;
          older_r[tgt_r] <= newest_r;
          newest_r <= tgt_r;
          state_r <= S_IDLE;
        end
        S_DROP: begin
          if (count_r > 1) begin
            if (tgt_r == oldest_r) oldest_r <= t_n;
            else if (tgt_r == newest_r) newest_r <= t_o;
            else begin
              newer_r[t_o] <= t_n;
              older_r[t_n] <= t_o;
            end
          end
          valid_r[tgt_r] <= 1'b0;
          count_r <= count_r - 1'b1;
          state_r <= S_IDLE;
        end
        S_TRD: begin
          tgt_r <= oldest_r;
          rd_id_r <= id_mem[oldest_r]; rd_hd_r <= hd_mem[oldest_r];
          rd_tm_r <= tm_mem[oldest_r]; rd_rt_r <= rt_mem[oldest_r];
          state_r <= S_TCHK;
        end
        S_TCHK: begin
          // wrapped age vs timeout
          if ((now_r - rd_tm_r) < {16'd0, timeout_r}) state_r <= S_IDLE;
          else state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid  <= 1'b1;
          out_ack_id <= rd_id_r;
          out_handle <= rd_hd_r;
          out_attempt <= rd_rt_r;
          if (rd_rt_r >= maxr_r) begin
            out_action <= prrt_pkg::ACT_FAIL;
            state_r <= S_DROP;
          end else begin
            out_action <= prrt_pkg::ACT_RETX;
            tm_mem[tgt_r] <= now_r;
            if (rd_rt_r != 4'hF) rt_mem[tgt_r] <= rd_rt_r + 1'b1;
            state_r <= (tgt_r == newest_r) ? S_IDLE : S_MOVE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
